// ===== rtl/ternary_min_heap_defines.svh =====
// Assertion macros for the ternary min heap.
`ifndef TERNARY_MIN_HEAP_DEFINES_SVH
`define TERNARY_MIN_HEAP_DEFINES_SVH
`ifndef SYNTHESIS
`define TMH_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TMH_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TMH_ASSERT(label, clk, rst_n, prop, msg)
`define TMH_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== rtl/tmh_pkg.sv =====
// Shared types and codes for the ternary min heap.
`timescale 1ns / 1ps
`default_nettype none
package tmh_pkg;
    localparam logic [1:0] MODE_INSERT   = 2'd0;
    localparam logic [1:0] MODE_DECREASE = 2'd1;
    localparam logic [1:0] MODE_EXTRACT  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_INDEX = 2'd3;

    localparam int IN_BITS  = 48;
    localparam int OUT_BITS = 48;
endpackage
`default_nettype wire

// ===== rtl/tmh_ram.sv =====
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module tmh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ===== rtl/ternary_min_heap.sv =====
// Top level of the ternary min heap: sequencer around one heap RAM.
//
//  channel  dir  tdata fields (low bit up)              handshake
//  s_axis   in   mode[1:0] key[33:2] index[43:34]        tvalid/tready
//  m_axis   out  status[1:0] min_value[33:2] count[44:34] tvalid/tready
//
// One item at a time; the heap RAM has one port, one access per cycle.
// Sift-up: per level moved, read the parent, then compare and write it down.
// Sift-down: per level moved, read up to three children, compare, write the smallest up.
// Rejected or empty items go straight to S_DONE; from S_DONE each result is
// handed over through the output register.
// rst_n clears the count and control; RAM contents need no reset.
// A result waits in the output register; the next item is taken only
// once that register is free.
`timescale 1ns / 1ps
`default_nettype none
`include "ternary_min_heap_defines.svh"
module ternary_min_heap #(
    parameter int CAPACITY  = 1024,
    parameter int KEY_WIDTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // mode, key, index
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata    // status, min_value, entry_count
);
    import tmh_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_EX_ROOT, S_EX_LAST, S_UP_CHK, S_UP_CMP, S_UP_FIN,
        S_DN_CHK, S_DN_CMP, S_DN_MOV, S_DN_FIN, S_DONE
    } state_t;

    state_t               state_reg;
    logic [CW-1:0]        count_reg;
    logic [AW-1:0]        pos_reg, best_reg;
    logic [KEY_WIDTH-1:0] cur_reg, best_key_reg;
    logic [1:0]           k_reg;
    logic [1:0]           status_reg;
    logic [31:0]          minv_reg;
    logic                 ovalid_reg;
    logic [47:0]          odata_reg;

    logic                 we;
    logic [AW-1:0]        addr;
    logic [KEY_WIDTH-1:0] wdata, rdata;

    tmh_ram #(.WIDTH(KEY_WIDTH), .DEPTH(CAPACITY)) u_ram (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    logic [1:0]           in_mode;
    logic [KEY_WIDTH-1:0] in_key;
    logic [9:0]           in_index;
    assign in_mode  = s_axis_tdata[1:0];
    assign in_key   = KEY_WIDTH'($signed(s_axis_tdata[33:2]));
    assign in_index = s_axis_tdata[43:34];

    logic full, idx_ok;
    assign full   = (count_reg >= CW'(CAPACITY));
    assign idx_ok = (17'(in_index) < 17'(count_reg));

    // parent = (pos-1)/3 by reciprocal multiply; exact for pos-1 below 2^17
    logic [16:0]   pm1;
    logic [32:0]   pprod;
    logic [AW-1:0] parent;
    assign pm1    = 17'(pos_reg) - 17'd1;
    assign pprod  = 33'(pm1) * 33'(16'd43691);
    assign parent = AW'(pprod[32:17]);

    // child 3*pos+1+k; in S_DN_CMP the data on rdata belongs to child_w-1
    logic [AW+1:0] child_w;
    logic          child_in;
    assign child_w  = (AW+2)'(pos_reg) * (AW+2)'(3) + (AW+2)'(k_reg) + (AW+2)'(1);
    assign child_in = (child_w < (AW+2)'(count_reg));

    logic up_swap, dn_better;
    assign up_swap   = ($signed(cur_reg) < $signed(rdata));
    assign dn_better = ($signed(rdata) < $signed(best_key_reg));

    assign s_axis_tready = (state_reg == S_IDLE) && !ovalid_reg;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;

    logic accept;
    assign accept = s_axis_tvalid && s_axis_tready;

    // Moving key lives in cur_reg; the hole at pos_reg is filled on exit.
    always_comb
    begin
        we    = 1'b0;
        addr  = pos_reg;
        wdata = cur_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_mode)
                        MODE_INSERT:
                        begin
                            we = !full; addr = AW'(count_reg); wdata = in_key;
                        end
                        MODE_DECREASE:
                        begin
                            we = idx_ok; addr = AW'(in_index); wdata = in_key;
                        end
                        MODE_EXTRACT: addr = '0;
                        default:      we = 1'b0;
                    endcase
                end
            end
            S_EX_ROOT: addr = AW'(count_reg - CW'(1));
            S_EX_LAST: addr = pos_reg;
            S_UP_CHK:  addr = parent;
            S_UP_CMP:
            begin
                // parent key moves down into the hole
                if (up_swap)
                begin
                    we = 1'b1; wdata = rdata;
                end
            end
            S_UP_FIN:  we = 1'b1;
            S_DN_CHK:  addr = AW'(child_w);
            S_DN_CMP:  addr = AW'(child_w);
            S_DN_MOV:
            begin
                // smallest child moves up into the hole
                if (best_reg != pos_reg)
                begin
                    we = 1'b1; wdata = best_key_reg;
                end
            end
            S_DN_FIN:  we = 1'b1;
            S_DONE:    addr = pos_reg;
            default:   addr = pos_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            ovalid_reg   <= 1'b0;
            odata_reg    <= '0;
            pos_reg      <= '0;
            best_reg     <= '0;
            cur_reg      <= '0;
            best_key_reg <= '0;
            k_reg        <= '0;
            status_reg   <= ST_OK;
            minv_reg     <= '0;
        end
        else
        begin
            if (state_reg == S_DONE)
            begin
                ovalid_reg <= 1'b1;
                odata_reg  <= {3'b000, 11'(count_reg), minv_reg, status_reg};
            end
            else if (m_axis_tready)
            begin
                ovalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        status_reg <= ST_OK;
                        minv_reg   <= '0;
                        cur_reg    <= in_key;
                        unique case (in_mode)
                            MODE_INSERT:
                            begin
                                if (full)
                                begin
                                    status_reg <= ST_FULL;
                                    state_reg  <= S_DONE;
                                end
                                else
                                begin
                                    pos_reg   <= AW'(count_reg);
                                    count_reg <= count_reg + CW'(1);
                                    state_reg <= S_UP_CHK;
                                end
                            end
                            MODE_DECREASE:
                            begin
                                if (!idx_ok)
                                begin
                                    status_reg <= ST_INDEX;
                                    state_reg  <= S_DONE;
                                end
                                else
                                begin
                                    pos_reg   <= AW'(in_index);
                                    state_reg <= S_UP_CHK;
                                end
                            end
                            MODE_EXTRACT:
                            begin
                                if (count_reg == '0)
                                begin
                                    status_reg <= ST_EMPTY;
                                    minv_reg   <= '1;
                                    state_reg  <= S_DONE;
                                end
                                else
                                begin
                                    state_reg <= S_EX_ROOT;
                                end
                            end
                            default: state_reg <= S_DONE;
                        endcase
                    end
                end
                S_EX_ROOT:
                begin
                    // root on rdata; last entry read this cycle
                    minv_reg  <= 32'(rdata);
                    count_reg <= count_reg - CW'(1);
                    state_reg <= S_EX_LAST;
                end
                S_EX_LAST:
                begin
                    cur_reg   <= rdata;
                    pos_reg   <= '0;
                    k_reg     <= '0;
                    state_reg <= S_DN_CHK;
                end
                S_UP_CHK:
                begin
                    if (pos_reg == '0)
                        state_reg <= S_UP_FIN;
                    else
                        state_reg <= S_UP_CMP;
                end
                S_UP_CMP:
                begin
                    if (up_swap)
                    begin
                        pos_reg   <= parent;
                        state_reg <= S_UP_CHK;
                    end
                    else
                        state_reg <= S_UP_FIN;
                end
                S_UP_FIN: state_reg <= S_DONE;
                S_DN_CHK:
                begin
                    if (!child_in)
                        state_reg <= S_DN_FIN;
                    else
                    begin
                        best_reg     <= pos_reg;
                        best_key_reg <= cur_reg;
                        k_reg        <= 2'd1;
                        state_reg    <= S_DN_CMP;
                    end
                end
                S_DN_CMP:
                begin
                    // strict compare keeps the first smallest child on ties
                    if (dn_better)
                    begin
                        best_key_reg <= rdata;
                        best_reg     <= AW'(child_w - (AW+2)'(1));
                    end
                    if (k_reg != 2'd3 && child_in)
                        k_reg <= k_reg + 2'd1;
                    else
                        state_reg <= S_DN_MOV;
                end
                S_DN_MOV:
                begin
                    if (best_reg == pos_reg)
                        state_reg <= S_DN_FIN;
                    else
                    begin
                        pos_reg   <= best_reg;
                        k_reg     <= '0;
                        state_reg <= S_DN_CHK;
                    end
                end
                S_DN_FIN: state_reg <= S_DONE;
                S_DONE:   state_reg <= S_IDLE;
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    `TMH_ASSERT(a_out_hold, clk, rst_n,
                m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata),
                "result changed while stalled")
    `TMH_ASSERT(a_in_gated, clk, rst_n,
                s_axis_tready |-> !m_axis_tvalid && state_reg == S_IDLE,
                "input taken while busy")
    `TMH_ASSERT(a_count_max, clk, rst_n, count_reg <= CW'(CAPACITY),
                "entry count above capacity")
    `TMH_ASSERT(a_done_valid, clk, rst_n, state_reg == S_DONE |=> m_axis_tvalid,
                "no result after item")
endmodule
`default_nettype wire

// ===== tb/sv/tb_ternary_min_heap.sv =====
// Testbench for the ternary min heap: stream stimulus, heap predictor, result checks.
`timescale 1ns / 1ps
`default_nettype none

// Predicts each result of the heap and checks the block's results against them.
class heap_scoreboard;
    logic signed [31:0] keys [0:1023];
    int unsigned        fill;
    logic [47:0]        pending [$];
    int                 n_bad;
    int                 n_seen;
    int                 n_extract;

    function new();
        fill = 0;
        n_bad = 0;
        n_seen = 0;
        n_extract = 0;
    endfunction

    function void swap_keys(int unsigned a, int unsigned b);
        logic signed [31:0] t;
        t = keys[a];
        keys[a] = keys[b];
        keys[b] = t;
    endfunction

    function void bubble_up(int unsigned pos);
        int unsigned up;
        while (pos > 0)
        begin
            up = (pos - 1) / 3;
            if (!(keys[pos] < keys[up]))
                break;
            swap_keys(pos, up);
            pos = up;
        end
    endfunction

    function void bubble_down();
        int unsigned pos;
        int unsigned best;
        int unsigned c;
        pos = 0;
        forever
        begin
            best = pos;
            for (int k = 1; k <= 3; k++)
            begin
                c = 3 * pos + k;
                if (c < fill && keys[c] < keys[best])
                    best = c;
            end
            if (best == pos)
                break;
            swap_keys(pos, best);
            pos = best;
        end
    endfunction

    // Notes an accepted operation and queues the result it must give.
    function void note_op(logic [47:0] word);
        logic [1:0]         mode;
        logic signed [31:0] key;
        logic [9:0]         idx;
        logic [1:0]         status;
        logic signed [31:0] minv;
        mode   = word[1:0];
        key    = word[33:2];
        idx    = word[43:34];
        status = tmh_pkg::ST_OK;
        minv   = 0;
        case (mode)
            tmh_pkg::MODE_INSERT:
                if (fill >= 1024)
                    status = tmh_pkg::ST_FULL;
                else
                begin
                    keys[fill] = key;
                    fill++;
                    bubble_up(fill - 1);
                end
            tmh_pkg::MODE_DECREASE:
                if (idx >= fill)
                    status = tmh_pkg::ST_INDEX;
                else
                begin
                    keys[idx] = key;
                    bubble_up(idx);
                end
            tmh_pkg::MODE_EXTRACT:
                if (fill == 0)
                begin
                    status = tmh_pkg::ST_EMPTY;
                    minv = -1;
                end
                else
                begin
                    minv = keys[0];
                    fill--;
                    keys[0] = keys[fill];
                    bubble_down();
                    n_extract++;
                end
            default: ;
        endcase
        pending.insert(pending.size(), {3'b0, 11'(fill), minv, status});
    endfunction

    // Compares one result with the oldest expected result.
    function void check_result(logic [47:0] got);
        logic [47:0] want;
        n_seen++;
        if (pending.size() == 0)
        begin
            n_bad++;
            if (n_bad <= 10)
                $display("ERROR: unexpected result %h", got);
            return;
        end
        want = pending.pop_front();
        if (got[1:0] !== want[1:0] || got[33:2] !== want[33:2]
            || got[44:34] !== want[44:34])
        begin
            n_bad++;
            if (n_bad <= 10)
                $display("ERROR: result %0d status %0d/%0d min %0d/%0d count %0d/%0d",
                         n_seen, want[1:0], got[1:0], $signed(want[33:2]),
                         $signed(got[33:2]), want[44:34], got[44:34]);
        end
    endfunction
endclass

module tb_ternary_min_heap;
    import tmh_pkg::*;

    localparam int RANDOM_OPS = 120;
    localparam int LIMIT      = 400000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;    // mode, key, index
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;    // status, min_value, entry_count

    heap_scoreboard heap_sb;
    int             cycles = 0;
    int             n_sent;

    ternary_min_heap i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Sends one operation; tvalid stays high across back-to-back items.
    task automatic send_op(logic [1:0] mode, logic [31:0] key, logic [9:0] idx);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, idx, key, mode};
        forever
        begin
            @(posedge clk);
            if (s_axis_tready)
                break;
        end
        heap_sb.note_op({4'b0, idx, key, mode});
        n_sent++;
        @(negedge clk);
    endtask

    task automatic pause_sender(int n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    function automatic logic [31:0] rand_key();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 20);
            default: return $urandom;
        endcase
    endfunction

    // Receiver: accepts results with its own stall pattern.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            heap_sb.check_result(m_axis_tdata);
    end

    always @(negedge clk)
    begin
        cycles <= cycles + 1;
        if ((cycles / 300) % 4 == 3)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        if (cycles > LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int burst;
        int target;
        logic [1:0] mode;
        heap_sb = new();
        n_sent = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty extract, bad index, extremes, ties, increase via decrease.
        send_op(MODE_EXTRACT, 32'd0, 10'd0);
        send_op(MODE_DECREASE, 32'd5, 10'd0);
        send_op(MODE_INSERT, 32'h7fff_ffff, 10'h3ff);
        send_op(MODE_INSERT, 32'h8000_0000, 10'd0);
        send_op(MODE_INSERT, 32'd7, 10'd0);
        send_op(MODE_INSERT, 32'd7, 10'd0);
        send_op(MODE_INSERT, 32'hffff_ffff, 10'd0);
        send_op(MODE_DECREASE, 32'h7fff_fffe, 10'd0);
        send_op(MODE_DECREASE, 32'h8000_0000, 10'd4);
        send_op(MODE_DECREASE, 32'd1, 10'd5);
        send_op(MODE_DECREASE, 32'd1, 10'h3ff);
        send_op(2'd3, 32'hffff_ffff, 10'h3ff);
        repeat (6) send_op(MODE_EXTRACT, 32'hffff_ffff, 10'h3ff);

        // Fill to capacity so the full case is reached, then overflow once.
        while (heap_sb.fill < 1024)
            send_op(MODE_INSERT, rand_key(), 10'($urandom));
        send_op(MODE_INSERT, 32'd3, 10'd0);
        send_op(MODE_DECREASE, 32'h8000_0000, 10'd1023);
        repeat (40) send_op(MODE_EXTRACT, 32'd0, 10'd0);

        // Random: mostly valid operations in bursts, drifting heap size.
        target = n_sent + RANDOM_OPS;
        while (n_sent < target)
        begin
            burst = $urandom_range(1, 30);
            repeat (burst)
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6: mode = MODE_INSERT;
                    7, 8, 9, 10:         mode = MODE_DECREASE;
                    19:                  mode = 2'd3;
                    default:             mode = MODE_EXTRACT;
                endcase
                if (mode == MODE_DECREASE && heap_sb.fill > 0 && $urandom_range(0, 7) != 0)
                    send_op(mode, rand_key(), 10'($urandom_range(0, heap_sb.fill - 1)));
                else
                    send_op(mode, rand_key(), 10'($urandom));
            end
            if ($urandom_range(0, 2) != 0)
                pause_sender($urandom_range(1, 60));
        end
        s_axis_tvalid <= 1'b0;

        while (heap_sb.pending.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);

        $display("Ran %0d heap operations (%0d extracts) with full, empty, index and tie cases.",
                 n_sent, heap_sb.n_extract);
        if (heap_sb.n_bad == 0 && heap_sb.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

`default_nettype wire
